/* hw/rtl/spssd_pkg.sv */
// Shared types, constants and the segment table for the setpoint key and display block.
package spssd_pkg;

   localparam int BIN_W     = 10;                 // setpoint and held temperature width
   localparam int BCD_W     = 12;                 // three decimal digits
   localparam int BIT_CNT_W = $clog2(BIN_W);
   localparam int DIGIT_COUNT = 6;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

   localparam logic [BIN_W-1:0] SHOW_MAX       = 10'd999;
   localparam logic [BIN_W-1:0] SETPOINT_RESET = 10'd38;
   localparam logic [BIN_W-1:0] FLOOR_RESET    = 10'd20;
   localparam logic [BIN_W-1:0] CEILING_RESET  = 10'd45;

   localparam logic [7:0] KEY_UP   = 8'h01;
   localparam logic [7:0] KEY_DOWN = 8'h10;

   // register index, taken from paddr[2]
   localparam logic CSR_FLOOR   = 1'b0;
   localparam logic CSR_CEILING = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } bcd_ctl_type;

   typedef struct packed {
      logic                   load;
      logic [DIGIT_IDX_W-1:0] index;
      logic [3:0]             digit;
   } out_cmd_type;

   function automatic logic [6:0] seg_code(input logic [3:0] d);
      logic [6:0] s;
      case (d)
         4'd0: s = 7'h3f;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5b;
         4'd3: s = 7'h4f;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6d;
         4'd6: s = 7'h7d;
         4'd7: s = 7'h27;
         4'd8: s = 7'h7f;
         4'd9: s = 7'h6f;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/spssd_bcd.sv */
// Bit-serial binary to BCD converter, one shift-and-adjust step per cycle while ctl.step is high.
module spssd_bcd (
   input  logic                      clock,
   input  spssd_pkg::bcd_ctl_type    ctl,
   input  logic [spssd_pkg::BIN_W-1:0] value,
   output logic [spssd_pkg::BCD_W-1:0] bcd
);
   import spssd_pkg::*;

   logic [BIN_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      for (int n = 0; n < BCD_W / 4; n++) begin
         adj[n*4 +: 4] = (bcd_ff[n*4 +: 4] >= 4'd5) ? bcd_ff[n*4 +: 4] + 4'd3
                                                    : bcd_ff[n*4 +: 4];
      end
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.start) begin
         bin_in = value;
         bcd_in = '0;
      end else if (ctl.step) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in = {bin_ff[BIN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

/* hw/rtl/spssd_out.sv */
// Result register: segment encode and digit select for one digit beat.
module spssd_out (
   input  logic                    clock,
   input  logic                    reset,
   input  spssd_pkg::out_cmd_type  cmd,
   output logic                    slot_free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [5:0]              rsp_digit_select,
   output logic [6:0]              rsp_segment_pattern,
   output logic                    rsp_last_digit
);
   import spssd_pkg::*;

   logic       valid_ff, valid_in;
   logic [5:0] select_ff, select_in;
   logic [6:0] seg_ff, seg_in;
   logic       last_ff, last_in;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      select_in = select_ff;
      seg_in    = seg_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         valid_in  = 1'b1;
         select_in = ~(6'd1 << cmd.index);
         seg_in    = seg_code(cmd.digit);
         last_in   = (cmd.index == DIGIT_IDX_W'(DIGIT_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      select_ff <= select_in;
      seg_ff    <= seg_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_digit_select    = select_ff;
   assign rsp_segment_pattern = seg_ff;
   assign rsp_last_digit      = last_ff;

endmodule

/* hw/rtl/setpoint_key_and_seven_segment_display.sv */
// Top level: pass counter, setpoint keys, config registers and display sequencing.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_switch_pins, req_temperature_sample
//  rsp      out        rsp_valid/rsp_stall  rsp_digit_select, rsp_segment_pattern,
//                                           rsp_last_digit
//  csr      in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// A sensor pass (pass counter at zero) gives no result.
// A display pass runs in order: key update on acceptance, a load state, the
// bit-serial BCD converters, then six digit beats.
// req_stall is high from acceptance until the sixth beat sits in the result register.
// rsp_stall holds the result register; the sequencer waits for it.
// Reset is synchronous; no clearing pass is needed.
module setpoint_key_and_seven_segment_display #(
   parameter int SENSOR_PERIOD_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_switch_pins,
   input  logic [13:0] req_temperature_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_digit_select,
   output logic [6:0]  rsp_segment_pattern,
   output logic        rsp_last_digit,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import spssd_pkg::*;

   state_type state_ff, state_in;

   logic [SENSOR_PERIOD_BITS-1:0] pass_cnt_ff;
   logic [BIN_W-1:0]              setpoint_ff, setpoint_in;
   logic [BIN_W-1:0]              held_temp_ff;
   logic [7:0]                    prev_keys_ff;
   logic [BIN_W-1:0]              floor_ff, ceiling_ff;
   logic [BIT_CNT_W-1:0]          bit_cnt_ff;
   logic [DIGIT_IDX_W-1:0]        idx_ff;

   logic        req_accept;
   logic        csr_write;
   logic [7:0]  keys;
   logic        sensor_pass;
   bcd_ctl_type bcd_ctl;
   out_cmd_type out_cmd;
   logic        slot_free;
   logic [BCD_W-1:0] sp_bcd, temp_bcd;
   logic [BIN_W-1:0] sp_shown;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign sensor_pass = (pass_cnt_ff == '0);
   assign keys        = ~req_switch_pins;
   assign pready      = 1'b1;
   assign csr_write   = psel && penable && pwrite;
   assign sp_shown    = (setpoint_ff > SHOW_MAX) ? SHOW_MAX : setpoint_ff;

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         CSR_FLOOR:   prdata = 32'(floor_ff);
         CSR_CEILING: prdata = 32'(ceiling_ff);
         default:     prdata = '0;
      endcase
   end

   // key handling; clamps are against the current registers
   always_comb begin
      setpoint_in = setpoint_ff;
      if (keys == KEY_UP) begin
         setpoint_in = (setpoint_ff >= ceiling_ff) ? ceiling_ff : setpoint_ff + 1'b1;
      end else if (keys == KEY_DOWN) begin
         setpoint_in = (setpoint_ff <= floor_ff) ? floor_ff : setpoint_ff - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      bcd_ctl  = '0;
      out_cmd  = '0;
      out_cmd.index = idx_ff;
      case (idx_ff)
         3'd0:    out_cmd.digit = sp_bcd[3:0];
         3'd1:    out_cmd.digit = sp_bcd[7:4];
         3'd2:    out_cmd.digit = sp_bcd[11:8];
         3'd3:    out_cmd.digit = temp_bcd[3:0];
         3'd4:    out_cmd.digit = temp_bcd[7:4];
         3'd5:    out_cmd.digit = temp_bcd[11:8];
         default: out_cmd.digit = 4'd0;
      endcase
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !sensor_pass) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            bcd_ctl.start = 1'b1;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            bcd_ctl.step = 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(BIN_W - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_cmd.load = 1'b1;
               if (idx_ff == DIGIT_IDX_W'(DIGIT_COUNT - 1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_cnt_ff  <= '0;
         setpoint_ff  <= SETPOINT_RESET;
         held_temp_ff <= '0;
         prev_keys_ff <= '0;
         floor_ff     <= FLOOR_RESET;
         ceiling_ff   <= CEILING_RESET;
         bit_cnt_ff   <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (paddr[2])
               CSR_FLOOR:   floor_ff   <= pwdata[BIN_W-1:0];
               CSR_CEILING: ceiling_ff <= pwdata[BIN_W-1:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            pass_cnt_ff <= pass_cnt_ff + 1'b1;
            if (sensor_pass) begin
               held_temp_ff <= (req_temperature_sample > 14'(SHOW_MAX)) ? SHOW_MAX
                                                   : req_temperature_sample[BIN_W-1:0];
            end else if (keys != prev_keys_ff) begin
               prev_keys_ff <= keys;
               setpoint_ff  <= setpoint_in;
            end
         end
         if (bcd_ctl.start) begin
            bit_cnt_ff <= '0;
            idx_ff     <= '0;
         end else if (bcd_ctl.step) begin
            bit_cnt_ff <= bit_cnt_ff + 1'b1;
         end
         if (out_cmd.load) idx_ff <= idx_ff + 1'b1;
      end
   end

   spssd_bcd u_sp_bcd (
      .clock (clock),
      .ctl   (bcd_ctl),
      .value (sp_shown),
      .bcd   (sp_bcd)
   );

   spssd_bcd u_temp_bcd (
      .clock (clock),
      .ctl   (bcd_ctl),
      .value (held_temp_ff),
      .bcd   (temp_bcd)
   );

   spssd_out u_out (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (out_cmd),
      .slot_free           (slot_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_last_digit      (rsp_last_digit)
   );

endmodule

/* tb/setpoint_key_and_seven_segment_display_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the setpoint key and seven-segment display block.
module setpoint_key_and_seven_segment_display_tb;
   import spssd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_PASSES   = 75;

   localparam logic [7:0] PINS_RELEASED = 8'hff;
   localparam logic [7:0] PINS_UP       = ~KEY_UP;
   localparam logic [7:0] PINS_DOWN     = ~KEY_DOWN;

   localparam logic [2:0] ADDR_FLOOR   = 3'd0;
   localparam logic [2:0] ADDR_CEILING = 3'd4;

   localparam logic [6:0] GLYPH [10] = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66,
                                         7'h6d, 7'h7d, 7'h27, 7'h7f, 7'h6f};

   typedef struct packed {
      logic [5:0] sel;
      logic [6:0] seg;
      logic       last;
   } digit_beat_type;

   class display_scoreboard;
      logic [9:0] floor_r, ceiling_r, setpoint_r, held_temp_r;
      logic [7:0] prev_keys_r, pass_cnt_r;
      digit_beat_type expected_digits[$];
      int errors, display_passes, sensor_passes, digits_checked, limit_writes;

      function new();
         floor_r        = FLOOR_RESET;
         ceiling_r      = CEILING_RESET;
         setpoint_r     = SETPOINT_RESET;
         held_temp_r    = '0;
         prev_keys_r    = '0;
         pass_cnt_r     = '0;
         errors         = 0;
         display_passes = 0;
         sensor_passes  = 0;
         digits_checked = 0;
         limit_writes   = 0;
      endfunction

      function void write_limit(logic idx, logic [31:0] data);
         if (idx == CSR_FLOOR) floor_r = data[BIN_W-1:0];
         else ceiling_r = data[BIN_W-1:0];
         limit_writes++;
      endfunction

      function void note_pass(logic [7:0] pins, logic [13:0] temp);
         logic [7:0] keys;
         int shown[2];
         int value, scale, digit;
         digit_beat_type beat;
         keys = ~pins;
         if (pass_cnt_r == '0) begin
            held_temp_r = (temp > SHOW_MAX) ? SHOW_MAX : temp[BIN_W-1:0];
            sensor_passes++;
         end else begin
            if (keys != prev_keys_r) begin
               if (keys == KEY_UP)
                  setpoint_r = (setpoint_r >= ceiling_r) ? ceiling_r : setpoint_r + 10'd1;
               else if (keys == KEY_DOWN)
                  setpoint_r = (setpoint_r <= floor_r) ? floor_r : setpoint_r - 10'd1;
               prev_keys_r = keys;
            end
            shown[0] = (setpoint_r > SHOW_MAX) ? SHOW_MAX : setpoint_r;
            shown[1] = held_temp_r;
            for (int k = 0; k < DIGIT_COUNT; k++) begin
               value = shown[k / 3];
               scale = (k % 3 == 0) ? 1 : (k % 3 == 1) ? 10 : 100;
               digit = (value / scale) % 10;
               beat.sel  = ~(6'd1 << k);
               beat.seg  = GLYPH[digit];
               beat.last = (k == DIGIT_COUNT - 1);
               expected_digits.push_back(beat);
            end
            display_passes++;
         end
         pass_cnt_r = pass_cnt_r + 8'd1;
      endfunction

      function void check_digit(logic [5:0] sel, logic [6:0] seg, logic last);
         digit_beat_type want;
         if (expected_digits.size() == 0) begin
            $error("unexpected digit beat: select %h, segments %h", sel, seg);
            errors++;
            return;
         end
         want = expected_digits.pop_front();
         digits_checked++;
         if (sel !== want.sel) begin
            $error("rsp_digit_select: expected %h, actual %h", want.sel, sel);
            errors++;
         end
         if (seg !== want.seg) begin
            $error("rsp_segment_pattern: expected %h, actual %h", want.seg, seg);
            errors++;
         end
         if (last !== want.last) begin
            $error("rsp_last_digit: expected %b, actual %b", want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_switch_pins = 8'hff;
   logic [13:0] req_temperature_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_digit_select;
   logic [6:0]  rsp_segment_pattern;
   logic        rsp_last_digit;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   display_scoreboard sb = new();
   bit calm = 1'b0;
   int sent_passes = 0;
   int quiet_cycles = 0;

   setpoint_key_and_seven_segment_display dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            sb.write_limit(paddr[2], pwdata);
         if (rsp_valid && !rsp_stall)
            sb.check_digit(rsp_digit_select, rsp_segment_pattern, rsp_last_digit);
         if (req_valid && !req_stall)
            sb.note_pass(req_switch_pins, req_temperature_sample);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("setpoint_key_and_seven_segment_display_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send_pass(input logic [7:0] pins, input logic [13:0] temp);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_switch_pins        <= pins;
      req_temperature_sample <= temp;
      do @(posedge clock); while (req_stall);
      sent_passes++;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [9:0] value);
      logic [31:0] word;
      word       = $urandom();
      word[9:0]  = value;   // upper bits are junk, the register keeps ten
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // limits only change with the block idle; a sensor pass leaves nothing to wait for
   task automatic set_limits(input logic [9:0] lo, input logic [9:0] hi);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(ADDR_FLOOR, lo);
      csr_write(ADDR_CEILING, hi);
   endtask

   function automatic logic [7:0] pick_pins(bit lean_up);
      int r;
      r = $urandom_range(99);
      if (r < 45) return (($urandom_range(99) < 80) == lean_up) ? PINS_UP : PINS_DOWN;
      if (r < 75) return PINS_RELEASED;
      return 8'($urandom());
   endfunction

   function automatic logic [13:0] pick_temperature();
      if (sent_passes % 256 != 0) return 14'($urandom());
      case ($urandom_range(4))
         0: return 14'd0;
         1: return 14'd999;
         2: return 14'd1000;
         3: return 14'h3fff;
         default: return 14'($urandom());
      endcase
   endfunction

   task automatic run_phase(input logic [9:0] lo, input logic [9:0] hi, input bit steady);
      set_limits(lo, hi);
      calm = steady;
      for (int i = 0; i < PHASE_PASSES; i++)
         send_pass(pick_pins(i < PHASE_PASSES / 2), pick_temperature());
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits: first beat is a sensor pass with a saturating reading
      send_pass(8'h00, 14'h3fff);
      send_pass(PINS_RELEASED, 14'd0);
      send_pass(PINS_UP, 14'h3fff);
      send_pass(PINS_UP, 14'd0);         // held key, no change
      send_pass(PINS_RELEASED, 14'h3fff);
      send_pass(PINS_DOWN, 14'd0);
      send_pass(8'h00, 14'h3fff);        // all keys: change without a code
      send_pass(8'hee, 14'd0);

      // floor above ceiling and out of the shown range
      set_limits(10'd1023, 10'd0);
      send_pass(PINS_UP, 14'h3fff);
      send_pass(PINS_RELEASED, 14'd0);
      send_pass(PINS_DOWN, 14'h3fff);    // jumps to 1023, shown as 999
      send_pass(PINS_DOWN, 14'd0);
      send_pass(PINS_RELEASED, 14'h3fff);
      send_pass(PINS_UP, 14'd0);
      send_pass(8'h55, 14'h3fff);
      send_pass(8'haa, 14'd0);
      send_pass(PINS_RELEASED, 14'h3fff);

      run_phase(10'd0, 10'd999, 1'b0);
      run_phase(10'd10, 10'd30, 1'b1);
      run_phase(10'd990, 10'd1023, 1'b0);
      run_phase(10'd0, 10'd0, 1'b0);
      run_phase(10'd400, 10'd380, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d display passes and %0d sensor passes, %0d digit beats checked",
               sb.display_passes, sb.sensor_passes, sb.digits_checked);
      $display("limit registers written %0d times, including inverted and out-of-range limits",
               sb.limit_writes);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("setpoint_key_and_seven_segment_display_tb: PASS");
      end else begin
         $display("setpoint_key_and_seven_segment_display_tb: FAIL");
      end
      $finish;
   end

endmodule
